/* src/utm_pkg.sv */
// Package with the shared types, constants and decode helpers of the text width measurer.
package utm_pkg;

    // Fixed field widths.
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 10;
    localparam int ENTRY_W = 16;
    localparam int BYTE_W  = 8;
    localparam int OUT_W   = 23;
    localparam int CODE_W  = 32;

    // Defaults for the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SUM_BITS_DEF    = 24;

    // Largest value the result field can carry.
    localparam logic [CODE_W-1:0] OUT_MAX = 32'd8388607;

    // Table entry value that marks a missing glyph.
    localparam logic [ENTRY_W-1:0] ENTRY_ABSENT = 16'hFFFF;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    // Code point of the newline character.
    localparam logic [CODE_W-1:0] CP_NEWLINE = 32'd10;

    // One input item.
    typedef struct packed {
        logic                       kind;
        logic [IDX_W-1:0]           entry_index;
        logic signed [ENTRY_W-1:0]  entry_width;
        logic [BYTE_W-1:0]          text_byte;
        logic                       last;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [OUT_W-1:0] max_width;
        logic             early_stop;
    } result_t;

    // Lead-byte classification: sequence class and an invalid flag.
    typedef struct packed {
        logic       bad;
        logic [1:0] cls;
    } lead_t;

    // Classify a byte seen in lead position.
    function automatic lead_t lead_class(input logic [BYTE_W-1:0] b);
        lead_t r;
        r.bad = 1'b0;
        r.cls = 2'd0;
        if (b < 8'h80) begin
            r.cls = 2'd0;
        end
        else if (b < 8'hC0) begin
            r.bad = 1'b1;
        end
        else if (b < 8'hE0) begin
            r.cls = 2'd1;
        end
        else if (b < 8'hF0) begin
            r.cls = 2'd2;
        end
        else if (b < 8'hF8) begin
            r.cls = 2'd3;
        end
        else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    // Offset removed from the assembled bits of a multi-byte sequence.
    function automatic logic [CODE_W-1:0] class_offset(input logic [1:0] cls);
        logic [CODE_W-1:0] r;
        case (cls)
            2'd1:    r = 32'd12416;
            2'd2:    r = 32'd925824;
            2'd3:    r = 32'd63447168;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

/* src/utm_stream_if.sv */
// Valid/ready stream interface used for the item and result channels.
interface utm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* src/utm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module utm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while the read enable is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/utf8_text_width_measure_top.sv */
// Top level of the UTF-8 text width measurer with its glyph advance table.
//
// Usage: the item channel carries either a table load (kind 0), which writes one
// signed advance width into the glyph table, or one byte of a UTF-8 string (kind 1).
// Decoded code points below entries_in_use whose table entry is not the absent mark
// add their width to the current line; such a newline closes the line first. The byte
// marked last produces one transfer on the result channel with the widest line
// width and a flag that tells whether a zero code point or an invalid lead byte
// stopped the measurement. Loads and other bytes produce no result.
// Throughput is one item per cycle while the item channel is ready. A result
// passes the input register and decoder, then the registered table read and the
// stage 2 registers, and leaves the line accumulator into the output register.
// After reset the glyph table is filled with the absent mark, one entry per cycle,
// so the item channel stays not ready until every entry is cleared; the configuration
// register can be written during that time.
// A result waiting in the output register does not stop the flow; only when a
// second result reaches the last stage while the first is still not taken does the
// pipeline hold and ready drop, apart from the clearing sweep.
module utf8_text_width_measure_top #(
    parameter int TABLE_DEPTH = utm_pkg::TABLE_DEPTH_DEF,
    parameter int SUM_BITS    = utm_pkg::SUM_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [utm_pkg::CFG_W-1:0] cfg_wdata,
    utm_stream_if.sink                item,
    utm_stream_if.source              result
);

    import utm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = SUM_BITS + 1;

    // Configuration register.
    logic [CFG_W-1:0] eiu_reg;

    // Table clearing sweep.
    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Input register (stage 1).
    logic  s1_valid_reg;
    item_t s1_reg;

    // Decoder state.
    logic [1:0]        pend_reg;
    logic [1:0]        cls_reg;
    logic [CODE_W-1:0] acc_reg;
    logic              stop_reg;
    logic [1:0]        pend_next;
    logic [1:0]        cls_next;
    logic [CODE_W-1:0] acc_next;
    logic              stop_next;

    // Stage 1 decode results.
    lead_t             lead;
    logic [CODE_W-1:0] acc_shift;
    logic [CODE_W-1:0] cp;
    logic              cp_done;
    logic              look;
    logic              is_text;
    logic              text_last;
    logic              load_we;
    logic [CODE_W-1:0] idx_ext;

    // Stage 2 registers.
    logic s2_valid_reg;
    logic s2_look_reg;
    logic s2_nl_reg;
    logic s2_last_reg;
    logic s2_stop_reg;

    // Line accumulators.
    logic signed [SUM_BITS-1:0] line_reg;
    logic signed [SUM_BITS-1:0] widest_reg;
    logic signed [SUM_BITS-1:0] line_next;
    logic signed [SUM_BITS-1:0] widest_next;

    // Stage 2 arithmetic.
    logic [ENTRY_W-1:0]         rdata;
    logic signed [ENTRY_W-1:0]  w;
    logic                       hit;
    logic                       fold;
    logic signed [SUM_BITS-1:0] base;
    logic signed [SW-1:0]       sum;
    logic signed [SUM_BITS-1:0] peak;
    logic [CODE_W-1:0]          peak_ext;
    logic [OUT_W-1:0]           max_width;

    // Output register.
    logic    out_valid_reg;
    result_t out_reg;

    // RAM port signals.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    logic adv;

    // The pipeline holds only when a second result would overwrite an untaken one.
    assign adv = !(s2_valid_reg && s2_last_reg && out_valid_reg && !result.ready);
    assign item.ready = adv && !clr_busy_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eiu_reg <= '0;
        end
        else if (cfg_we)
        begin
            eiu_reg <= cfg_wdata;
        end
    end

    // Clearing sweep after reset fills every table entry with the absent mark.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(TABLE_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item.valid && item.ready;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= item.data;
        end
    end

    // UTF-8 decoder: assembles code points and tracks the stop condition.
    always_comb
    begin
        pend_next = pend_reg;
        cls_next  = cls_reg;
        acc_next  = acc_reg;
        stop_next = stop_reg;
        cp        = '0;
        cp_done   = 1'b0;
        lead      = lead_class(s1_reg.text_byte);
        acc_shift = (acc_reg << 6) + CODE_W'(s1_reg.text_byte);
        is_text   = s1_valid_reg && (s1_reg.kind == KIND_TEXT);
        if (is_text && !stop_reg)
        begin
            if (pend_reg != 2'd0)
            begin
                acc_next  = acc_shift;
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1)
                begin
                    cp       = acc_shift - class_offset(cls_reg);
                    cp_done  = 1'b1;
                    acc_next = '0;
                    cls_next = 2'd0;
                end
            end
            else if (lead.bad)
            begin
                stop_next = 1'b1;
            end
            else if (lead.cls == 2'd0)
            begin
                cp      = CODE_W'(s1_reg.text_byte);
                cp_done = 1'b1;
            end
            else
            begin
                cls_next  = lead.cls;
                pend_next = lead.cls;
                acc_next  = CODE_W'(s1_reg.text_byte);
            end
        end
        // A zero code point ends the measurement.
        if (cp_done && (cp == '0))
        begin
            stop_next = 1'b1;
        end
        look = cp_done && (cp != '0) && (cp < CODE_W'(eiu_reg))
            && (cp < CODE_W'(TABLE_DEPTH));
        text_last = is_text && s1_reg.last;
    end

    // Decoder state; the last byte of a string clears it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            cls_reg  <= 2'd0;
            acc_reg  <= '0;
            stop_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (text_last)
            begin
                pend_reg <= 2'd0;
                cls_reg  <= 2'd0;
                acc_reg  <= '0;
                stop_reg <= 1'b0;
            end
            else
            begin
                pend_reg <= pend_next;
                cls_reg  <= cls_next;
                acc_reg  <= acc_next;
                stop_reg <= stop_next;
            end
        end
    end

    // Table loads write the RAM; the sweep owns the write port after reset.
    assign idx_ext   = CODE_W'(s1_reg.entry_index);
    assign load_we   = adv && s1_valid_reg && (s1_reg.kind == KIND_LOAD)
        && (idx_ext < CODE_W'(TABLE_DEPTH));
    assign ram_we    = clr_busy_reg || load_we;
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : idx_ext[AW-1:0];
    assign ram_wdata = clr_busy_reg ? ENTRY_ABSENT : s1_reg.entry_width;

    utm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (cp[AW-1:0]),
        .rdata (rdata)
    );

    // Stage 2 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_look_reg  <= 1'b0;
            s2_nl_reg    <= 1'b0;
            s2_last_reg  <= 1'b0;
            s2_stop_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_look_reg  <= look;
            s2_nl_reg    <= (cp == CP_NEWLINE);
            s2_last_reg  <= text_last;
            s2_stop_reg  <= stop_next;
        end
    end

    // Line accumulation with newline fold and signed saturation.
    always_comb
    begin
        w    = $signed(rdata);
        hit  = s2_valid_reg && s2_look_reg && (rdata != ENTRY_ABSENT);
        fold = hit && s2_nl_reg;
        widest_next = widest_reg;
        base        = line_reg;
        if (fold)
        begin
            if (line_reg > widest_reg)
            begin
                widest_next = line_reg;
            end
            base = '0;
        end
        sum = SW'(base) + SW'(w);
        line_next = line_reg;
        if (hit)
        begin
            if (sum[SW-1] != sum[SW-2])
            begin
                line_next = sum[SW-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                      : {1'b0, {(SUM_BITS-1){1'b1}}};
            end
            else
            begin
                line_next = sum[SUM_BITS-1:0];
            end
        end
        // Widest line of the string, clamped to the result range.
        peak = (line_next > widest_next) ? line_next : widest_next;
        if (peak[SUM_BITS-1])
        begin
            peak_ext = '0;
        end
        else
        begin
            peak_ext = CODE_W'($unsigned(peak));
        end
        if (peak_ext > OUT_MAX)
        begin
            max_width = OUT_MAX[OUT_W-1:0];
        end
        else
        begin
            max_width = peak_ext[OUT_W-1:0];
        end
    end

    // Line state; the last byte of a string clears it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= '0;
            widest_reg <= '0;
        end
        else if (adv && s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                line_reg   <= '0;
                widest_reg <= '0;
            end
            else
            begin
                line_reg   <= line_next;
                widest_reg <= widest_next;
            end
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && s2_valid_reg && s2_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg && s2_last_reg)
        begin
            out_reg.max_width  <= max_width;
            out_reg.early_stop <= s2_stop_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // No result can be pending while the table is still being cleared.
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !out_valid_reg)
        else $error("result valid during table clearing");

    // The decoder never waits for more bytes than its sequence class allows.
    a_pend_le_class: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= cls_reg)
        else $error("pending byte count exceeds sequence class");

    // The widest line is never negative.
    a_widest_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !widest_reg[SUM_BITS-1])
        else $error("widest line went negative");

    // A last byte leaving the accumulator always lands in the output register.
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg && s2_last_reg) |=> out_valid_reg)
        else $error("last byte did not produce a result");

endmodule
